// ----- sv/shp_pkg.sv -----
package shp_pkg;

   localparam int DigestBytes = 20;
   localparam int SeedItemBytes = 8;
   localparam logic [3:0] ReseedPeriodM1 = 4'd9;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_GEN  = 1'b1;

   localparam logic [159:0] SHA_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   typedef struct packed {
      logic        op;
      logic [63:0] seed_word;
      logic [8:0]  byte_count;
      logic        seed_last;
   } item_type;

   typedef struct packed {
      logic         start;
      logic [159:0] h_in;
      logic [511:0] blk;
   } core_cmd_type;

   typedef struct packed {
      logic         done;
      logic [159:0] h_out;
   } core_sts_type;

   function automatic logic [63:0] cnt_le(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[63-8*i -: 8] = v[8*i +: 8];
      end
      return r;
   endfunction

   // counter | state | seed, 48 bytes, single-block padding
   function automatic logic [511:0] gen_block(input logic [63:0] cnt,
                                              input logic [159:0] st,
                                              input logic [159:0] sd);
      return {cnt_le(cnt), st, sd, 8'h80, 104'h0, 16'h0180};
   endfunction

   // seed | counter, 28 bytes, single-block padding
   function automatic logic [511:0] reseed_block(input logic [159:0] sd,
                                                 input logic [63:0] cnt);
      return {sd, cnt_le(cnt), 8'h80, 264'h0, 16'h00E0};
   endfunction

endpackage

// ----- sv/shp_front.sv -----
module shp_front #(
   parameter int MAX_REQUEST_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [79:0]       req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              q_valid,
   input  logic              q_ready,
   output shp_pkg::item_type q_item
);
   import shp_pkg::*;

   localparam logic [8:0] MaxReq = 9'(MAX_REQUEST_BYTES);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, pop;

   always_comb begin
      cls.op         = req_tuser;
      cls.seed_word  = req_tdata[63:0];
      cls.seed_last  = req_tlast;
      cls.byte_count = req_tdata[72:64];
      // clamp seed counts to one item and requests to the maximum
      if (req_tuser == OP_SEED) begin
         if (req_tdata[72:64] > 9'(SeedItemBytes)) cls.byte_count = 9'(SeedItemBytes);
      end else begin
         if (req_tdata[72:64] > MaxReq) cls.byte_count = MaxReq;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= cls;
   end

endmodule

// ----- sv/shp_sha1_core.sv -----
module shp_sha1_core (
   input  logic                  clock,
   input  logic                  reset,
   input  shp_pkg::core_cmd_type cmd,
   output shp_pkg::core_sts_type sts
);
   import shp_pkg::*;

   logic [159:0] h_ff;
   logic [511:0] win_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]   rnd_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  f, k, t, wnew;

   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'hCA62C1D6;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + win_ff[511:480];
      wnew = win_ff[511-32*13 -: 32] ^ win_ff[511-32*8 -: 32]
           ^ win_ff[511-32*2 -: 32] ^ win_ff[511:480];
   end

   assign sts.done  = done_ff;
   assign sts.h_out = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                       h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= 7'd0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (cmd.start) begin
         h_ff   <= cmd.h_in;
         win_ff <= cmd.blk;
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= cmd.h_in;
      end else if (busy_ff) begin
         win_ff <= {win_ff[479:0], wnew[30:0], wnew[31]};
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= t;
      end
   end

endmodule

// ----- sv/shp_engine.sv -----
module shp_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  shp_pkg::item_type     q_item,
   output shp_pkg::core_cmd_type cmd,
   input  shp_pkg::core_sts_type sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   output logic                  rsp_tlast
);
   import shp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPFX, ST_SDATA, ST_PAD80, ST_PADZ, ST_PADLEN, ST_SCOMP, ST_SWAIT,
      ST_SFIN, ST_GBLK, ST_GWAIT, ST_RWAIT, ST_GOUT
   } state_type;

   state_type    state_ff, ret_ff;
   item_type     item_ff;
   logic [4:0]   idx_ff;
   logic [159:0] seed_ff, gstate_ff, chain_ff;
   logic [63:0]  cnt_ff, len_ff, bits_ff;
   logic [3:0]   mod_ff, mod_in;
   logic [511:0] blk_ff;
   logic [8:0]   rem_ff;
   logic [4:0]   off_ff;
   logic [1:0]   wpos_ff;
   logic [31:0]  word_ff, word_in;
   logic         ovalid_ff, olast_ff;
   logic [31:0]  odata_ff;
   logic [2:0]   obytes_ff;
   logic [63:0]  cnt_in;
   logic         ab_go, slot_free, emit, word_go;
   logic [7:0]   ab_byte, gbyte;
   state_type    ab_next;
   logic [4:0]   ab_idx;

   assign q_ready    = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {5'd0, obytes_ff, odata_ff};
   assign slot_free  = !ovalid_ff || rsp_tready;

   assign cnt_in = cnt_ff + 64'd1;
   assign mod_in = (cnt_ff == '1 || mod_ff == ReseedPeriodM1) ? 4'd0 : mod_ff + 4'd1;
   assign gbyte  = gstate_ff[159-8*off_ff -: 8];
   assign emit   = (wpos_ff == 2'd3) || (rem_ff == 9'd1);
   assign word_in = word_ff | ({24'd0, gbyte} << {wpos_ff, 3'b000});
   // a finished word moves into the result register
   assign word_go = (state_ff == ST_GOUT) && (rem_ff != 9'd0)
                 && (off_ff != 5'(DigestBytes)) && emit && slot_free;

   // byte to absorb into the open seed run
   always_comb begin
      ab_go   = 1'b0;
      ab_byte = 8'h00;
      ab_next = state_ff;
      ab_idx  = idx_ff + 5'd1;
      unique case (state_ff)
         ST_SPFX: begin
            ab_go   = 1'b1;
            ab_byte = seed_ff[159-8*idx_ff -: 8];
            if (idx_ff == 5'(DigestBytes - 1)) begin
               ab_next = ST_SDATA;
               ab_idx  = 5'd0;
            end
         end
         ST_SDATA: begin
            ab_go   = (idx_ff != item_ff.byte_count[4:0]);
            ab_byte = item_ff.seed_word[8*idx_ff[2:0] +: 8];
         end
         ST_PAD80: begin
            ab_go   = 1'b1;
            ab_byte = 8'h80;
            ab_next = ST_PADZ;
            ab_idx  = 5'd0;
         end
         ST_PADZ: begin
            ab_go   = (len_ff[5:0] != 6'd56);
            ab_idx  = 5'd0;
         end
         ST_PADLEN: begin
            ab_go   = 1'b1;
            ab_byte = bits_ff[63-8*idx_ff[2:0] -: 8];
            if (idx_ff == 5'd7) ab_next = ST_SFIN;
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd.start = 1'b0;
      cmd.h_in  = SHA_IV;
      cmd.blk   = gen_block(cnt_ff, gstate_ff, seed_ff);
      unique case (state_ff)
         ST_SCOMP: begin
            cmd.start = 1'b1;
            cmd.h_in  = chain_ff;
            cmd.blk   = blk_ff;
         end
         ST_GBLK: cmd.start = 1'b1;
         ST_GWAIT: begin
            cmd.start = sts.done && (mod_in == 4'd0);
            cmd.blk   = reseed_block(seed_ff, cnt_in);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         seed_ff   <= '0;
         gstate_ff <= '0;
         cnt_ff    <= '0;
         mod_ff    <= 4'd0;
         chain_ff  <= SHA_IV;
         len_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (word_go) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
         if (ab_go) begin
            blk_ff[511-8*len_ff[5:0] -: 8] <= ab_byte;
            len_ff <= len_ff + 64'd1;
            idx_ff <= ab_idx;
            if (len_ff[5:0] == 6'd63) begin
               ret_ff   <= ab_next;
               state_ff <= ST_SCOMP;
            end else begin
               state_ff <= ab_next;
            end
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (q_valid) begin
                     item_ff <= q_item;
                     idx_ff  <= 5'd0;
                     off_ff  <= 5'd0;
                     rem_ff  <= q_item.byte_count;
                     wpos_ff <= 2'd0;
                     word_ff <= 32'd0;
                     if (q_item.op == OP_GEN) state_ff <= ST_GBLK;
                     else if (len_ff == 64'd0) state_ff <= ST_SPFX;
                     else state_ff <= ST_SDATA;
                  end
               end
               ST_SDATA: begin
                  // item done: finish the run or wait for more
                  if (item_ff.seed_last) begin
                     bits_ff  <= {len_ff[60:0], 3'b000};
                     state_ff <= ST_PAD80;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_PADZ: state_ff <= ST_PADLEN;
               ST_SCOMP: state_ff <= ST_SWAIT;
               ST_SWAIT: begin
                  if (sts.done) begin
                     chain_ff <= sts.h_out;
                     state_ff <= ret_ff;
                  end
               end
               ST_SFIN: begin
                  seed_ff  <= chain_ff;
                  chain_ff <= SHA_IV;
                  len_ff   <= '0;
                  state_ff <= ST_IDLE;
               end
               ST_GBLK: state_ff <= ST_GWAIT;
               ST_GWAIT: begin
                  if (sts.done) begin
                     gstate_ff <= sts.h_out;
                     cnt_ff    <= cnt_in;
                     mod_ff    <= mod_in;
                     state_ff  <= (mod_in == 4'd0) ? ST_RWAIT : ST_GOUT;
                  end
               end
               ST_RWAIT: begin
                  if (sts.done) begin
                     seed_ff  <= sts.h_out;
                     state_ff <= ST_GOUT;
                  end
               end
               ST_GOUT: begin
                  if (rem_ff == 9'd0) begin
                     state_ff <= ST_IDLE;
                  end else if (off_ff == 5'(DigestBytes)) begin
                     off_ff   <= 5'd0;
                     state_ff <= ST_GBLK;
                  end else if (!emit || slot_free) begin
                     rem_ff <= rem_ff - 9'd1;
                     off_ff <= off_ff + 5'd1;
                     if (emit) begin
                        odata_ff  <= word_in;
                        obytes_ff <= {1'b0, wpos_ff} + 3'd1;
                        olast_ff  <= (rem_ff == 9'd1);
                        word_ff   <= 32'd0;
                        wpos_ff   <= 2'd0;
                     end else begin
                        word_ff <= word_in;
                        wpos_ff <= wpos_ff + 2'd1;
                     end
                  end
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

endmodule

// ----- sv/sha1_hash_prng.sv -----
// channel | ports          | payload
// request | req_t*         | tdata: seed_word, byte_count; tuser: op; tlast: seed_last
// result  | rsp_t*         | tdata: out_data, out_bytes; tlast: out_last
//
// Each SHA-1 compression runs in one shared iterative core (one round a cycle). A seed
// item costs one compression per filled 64-byte block; a request costs one compression
// per 20 bytes (at least one), one more on every tenth counter value, and a 256-byte
// request holds at most two such reseeds. Reset clears the state machines, the queue
// pointers and the seed state; a two-entry request queue keeps accepting while not full
// during work, and the result register stalls the byte unpacker only when a word is
// ready and not taken.
module sha1_hash_prng #(
   parameter int MAX_REQUEST_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // seed_word[63:0], byte_count[72:64]
   input  logic        req_tuser,   // op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_data[31:0], out_bytes[34:32]
   output logic        rsp_tlast
);
   import shp_pkg::*;

   logic         q_valid, q_ready;
   item_type     q_item;
   core_cmd_type cmd;
   core_sts_type sts;

   shp_front #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .q_valid, .q_ready, .q_item
   );

   shp_engine u_engine (
      .clock, .reset, .q_valid, .q_ready, .q_item, .cmd, .sts,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   shp_sha1_core u_core (.clock, .reset, .cmd, .sts);

endmodule

// ----- sv/shp_checker.sv -----
module shp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] != 3'd0 && rsp_tdata[34:32] <= 3'd4)
      else $error("byte count out of range");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[34:32] == 3'd4)
      else $error("short word before end of request");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sha1_hash_prng shp_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
